[rtl/core/double_ended_queue_assert.svh]
// assertion macros shared by the deque checker
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication
`define DEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/deq_pkg.sv]
// package with types and constants for the double-ended queue
package deq_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FUNC_W         = 3;
    localparam int VALUE_W        = 32;
    localparam int INDEX_W        = 8;
    localparam int RDATA_W        = 32;
    localparam int STATUS_W       = 2;
    localparam int COUNT_W        = 9;

    typedef enum logic [FUNC_W-1:0] {
        F_PUSH_BACK  = 3'd0,
        F_PUSH_FRONT = 3'd1,
        F_POP_BACK   = 3'd2,
        F_POP_FRONT  = 3'd3,
        F_READ       = 3'd4,
        F_WRITE      = 3'd5,
        F_INSERT     = 3'd6,
        F_ERASE      = 3'd7
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RES
    } t_state;

    typedef enum logic [2:0] {
        OF_ZERO,
        OF_INDEX,
        OF_COUNT,
        OF_COUNT_M1,
        OF_LAST,
        OF_PTR,
        OF_PTR_M1,
        OF_PTR_P1
    } t_offs_sel;

    typedef struct packed {
        logic      load;
        logic      rd_en;
        logic      wr_en;
        logic      wr_from_mem;
        t_offs_sel offs;
        logic      ptr_init;
        logic      ptr_from_index;
        logic      ptr_inc;
        logic      ptr_dec;
        logic      commit;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  fail;
        logic  shift_done;
        logic  out_free;
    } t_dp_status;

endpackage

[rtl/core/deq_ctrl.sv]
// controller state machine sequencing each deque operation
module deq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  deq_pkg::t_dp_status i_status,
    output logic                o_in_stall,
    output deq_pkg::t_cmd       o_cmd
);

    deq_pkg::t_state r_state;
    deq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= deq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            deq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = deq_pkg::S_EXEC;
                end
            end
            deq_pkg::S_EXEC: begin
                if (!i_status.fail &&
                    (i_status.func == deq_pkg::F_INSERT ||
                     i_status.func == deq_pkg::F_ERASE)) begin
                    n_state = deq_pkg::S_SHIFT_RD;
                end else begin
                    n_state = deq_pkg::S_RES;
                end
            end
            deq_pkg::S_SHIFT_RD: begin
                if (i_status.shift_done) begin
                    n_state = deq_pkg::S_RES;
                end else begin
                    n_state = deq_pkg::S_SHIFT_WR;
                end
            end
            deq_pkg::S_SHIFT_WR: begin
                n_state = deq_pkg::S_SHIFT_RD;
            end
            deq_pkg::S_RES: begin
                if (i_status.out_free) begin
                    n_state = deq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = deq_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall           = 1'b1;
        o_cmd.load           = 1'b0;
        o_cmd.rd_en          = 1'b0;
        o_cmd.wr_en          = 1'b0;
        o_cmd.wr_from_mem    = 1'b0;
        o_cmd.offs           = deq_pkg::OF_ZERO;
        o_cmd.ptr_init       = 1'b0;
        o_cmd.ptr_from_index = 1'b0;
        o_cmd.ptr_inc        = 1'b0;
        o_cmd.ptr_dec        = 1'b0;
        o_cmd.commit         = 1'b0;
        case (r_state)
            deq_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            deq_pkg::S_EXEC: begin
                if (!i_status.fail) begin
                    case (i_status.func)
                        deq_pkg::F_PUSH_BACK: begin
                            o_cmd.wr_en = 1'b1;
                            o_cmd.offs  = deq_pkg::OF_COUNT;
                        end
                        deq_pkg::F_PUSH_FRONT: begin
                            o_cmd.wr_en = 1'b1;
                            o_cmd.offs  = deq_pkg::OF_LAST;
                        end
                        deq_pkg::F_POP_BACK: begin
                            o_cmd.rd_en = 1'b1;
                            o_cmd.offs  = deq_pkg::OF_COUNT_M1;
                        end
                        deq_pkg::F_POP_FRONT: begin
                            o_cmd.rd_en = 1'b1;
                            o_cmd.offs  = deq_pkg::OF_ZERO;
                        end
                        deq_pkg::F_READ: begin
                            o_cmd.rd_en = 1'b1;
                            o_cmd.offs  = deq_pkg::OF_INDEX;
                        end
                        deq_pkg::F_WRITE: begin
                            o_cmd.wr_en = 1'b1;
                            o_cmd.offs  = deq_pkg::OF_INDEX;
                        end
                        deq_pkg::F_INSERT: begin
                            o_cmd.ptr_init = 1'b1;
                        end
                        deq_pkg::F_ERASE: begin
                            o_cmd.ptr_init       = 1'b1;
                            o_cmd.ptr_from_index = 1'b1;
                        end
                        default: begin
                            o_cmd.offs = deq_pkg::OF_ZERO;
                        end
                    endcase
                end
            end
            deq_pkg::S_SHIFT_RD: begin
                if (i_status.shift_done) begin
                    if (i_status.func == deq_pkg::F_INSERT) begin
                        o_cmd.wr_en = 1'b1;
                        o_cmd.offs  = deq_pkg::OF_INDEX;
                    end
                end else begin
                    o_cmd.rd_en = 1'b1;
                    if (i_status.func == deq_pkg::F_INSERT) begin
                        o_cmd.offs = deq_pkg::OF_PTR_M1;
                    end else begin
                        o_cmd.offs = deq_pkg::OF_PTR_P1;
                    end
                end
            end
            deq_pkg::S_SHIFT_WR: begin
                o_cmd.wr_en       = 1'b1;
                o_cmd.wr_from_mem = 1'b1;
                o_cmd.offs        = deq_pkg::OF_PTR;
                if (i_status.func == deq_pkg::F_INSERT) begin
                    o_cmd.ptr_dec = 1'b1;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            deq_pkg::S_RES: begin
                o_cmd.commit = i_status.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

[rtl/core/deq_datapath.sv]
// ring store, pointers, count and result register of the deque
module deq_datapath #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [deq_pkg::FUNC_W-1:0]    i_func,
    input  logic [deq_pkg::VALUE_W-1:0]   i_value,
    input  logic [deq_pkg::INDEX_W-1:0]   i_index,
    input  deq_pkg::t_cmd                 i_cmd,
    input  logic                          i_out_stall,
    output deq_pkg::t_dp_status           o_status,
    output logic                          o_out_valid,
    output logic [deq_pkg::RDATA_W-1:0]   o_read_data,
    output logic [deq_pkg::STATUS_W-1:0]  o_status_code,
    output logic [deq_pkg::COUNT_W-1:0]   o_entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = (CW > deq_pkg::INDEX_W) ? CW : deq_pkg::INDEX_W;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_mem_q;

    deq_pkg::t_func              r_func;
    logic [DATA_WIDTH-1:0]       r_value;
    logic [deq_pkg::INDEX_W-1:0] r_index;
    logic [AW-1:0]               r_head;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_ptr;

    logic                        r_out_valid;
    logic [deq_pkg::RDATA_W-1:0] r_out_data;
    deq_pkg::t_status            r_out_status;
    logic [deq_pkg::COUNT_W-1:0] r_out_count;

    logic [DATA_WIDTH-1:0]       in_word;
    logic [deq_pkg::RDATA_W-1:0] mem_word_out;
    logic [deq_pkg::COUNT_W-1:0] count_out;

    logic [OW-1:0]       idx_ow;
    logic [OW-1:0]       cnt_ow;
    logic [CW-1:0]       idx_cw;
    logic                is_full;
    logic                is_empty;
    deq_pkg::t_status    code;
    logic                ok;
    logic                shift_done;
    logic                out_free;
    logic [CW-1:0]       offs;
    logic [CW:0]         sum;
    logic [AW-1:0]       addr;
    logic [AW-1:0]       head_inc;
    logic [AW-1:0]       head_dec;
    logic                rd_result;
    logic [AW-1:0]       n_head;
    logic [CW-1:0]       n_count;

    // width adaption of data and count
    generate
        if (DATA_WIDTH <= deq_pkg::VALUE_W) begin : g_in_trunc
            assign in_word = i_value[DATA_WIDTH-1:0];
        end else begin : g_in_ext
            assign in_word = {{(DATA_WIDTH - deq_pkg::VALUE_W){1'b0}}, i_value};
        end
        if (DATA_WIDTH >= deq_pkg::RDATA_W) begin : g_out_trunc
            assign mem_word_out = r_mem_q[deq_pkg::RDATA_W-1:0];
        end else begin : g_out_ext
            assign mem_word_out = {{(deq_pkg::RDATA_W - DATA_WIDTH){1'b0}}, r_mem_q};
        end
        if (CW >= deq_pkg::COUNT_W) begin : g_cnt_trunc
            assign count_out = n_count[deq_pkg::COUNT_W-1:0];
        end else begin : g_cnt_ext
            assign count_out = {{(deq_pkg::COUNT_W - CW){1'b0}}, n_count};
        end
    endgenerate

    assign idx_ow   = OW'(r_index);
    assign cnt_ow   = OW'(r_count);
    assign idx_cw   = CW'(idx_ow);
    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    // outcome of the held item
    always_comb begin
        code = deq_pkg::ST_OK;
        case (r_func)
            deq_pkg::F_PUSH_BACK, deq_pkg::F_PUSH_FRONT: begin
                if (is_full) begin
                    code = deq_pkg::ST_FULL;
                end
            end
            deq_pkg::F_POP_BACK, deq_pkg::F_POP_FRONT: begin
                if (is_empty) begin
                    code = deq_pkg::ST_EMPTY;
                end
            end
            deq_pkg::F_INSERT: begin
                if (idx_ow > cnt_ow) begin
                    code = deq_pkg::ST_EMPTY;
                end else if (is_full) begin
                    code = deq_pkg::ST_FULL;
                end
            end
            deq_pkg::F_READ, deq_pkg::F_WRITE, deq_pkg::F_ERASE: begin
                if (idx_ow >= cnt_ow) begin
                    code = deq_pkg::ST_EMPTY;
                end
            end
            default: begin
                code = deq_pkg::ST_EMPTY;
            end
        endcase
    end

    assign ok = (code == deq_pkg::ST_OK);

    always_comb begin
        if (r_func == deq_pkg::F_INSERT) begin
            shift_done = (r_ptr == idx_cw);
        end else begin
            shift_done = (({1'b0, r_ptr} + (CW + 1)'(1)) >= {1'b0, r_count});
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    assign o_status.func       = r_func;
    assign o_status.fail       = !ok;
    assign o_status.shift_done = shift_done;
    assign o_status.out_free   = out_free;

    // logical offset to ring address
    always_comb begin
        case (i_cmd.offs)
            deq_pkg::OF_ZERO:     offs = '0;
            deq_pkg::OF_INDEX:    offs = idx_cw;
            deq_pkg::OF_COUNT:    offs = r_count;
            deq_pkg::OF_COUNT_M1: offs = r_count - CW'(1);
            deq_pkg::OF_LAST:     offs = CW'(DEPTH - 1);
            deq_pkg::OF_PTR:      offs = r_ptr;
            deq_pkg::OF_PTR_M1:   offs = r_ptr - CW'(1);
            deq_pkg::OF_PTR_P1:   offs = r_ptr + CW'(1);
            default:              offs = '0;
        endcase
    end

    assign sum = {1'b0, CW'(r_head)} + {1'b0, offs};

    always_comb begin
        if (sum >= (CW + 1)'(DEPTH)) begin
            addr = AW'(sum - (CW + 1)'(DEPTH));
        end else begin
            addr = AW'(sum);
        end
    end

    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);

    // state after the item
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (ok) begin
            case (r_func)
                deq_pkg::F_PUSH_BACK, deq_pkg::F_INSERT: begin
                    n_count = r_count + CW'(1);
                end
                deq_pkg::F_PUSH_FRONT: begin
                    n_head  = head_dec;
                    n_count = r_count + CW'(1);
                end
                deq_pkg::F_POP_BACK, deq_pkg::F_ERASE: begin
                    n_count = r_count - CW'(1);
                end
                deq_pkg::F_POP_FRONT: begin
                    n_head  = head_inc;
                    n_count = r_count - CW'(1);
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    assign rd_result = ok && (r_func == deq_pkg::F_POP_BACK ||
                              r_func == deq_pkg::F_POP_FRONT ||
                              r_func == deq_pkg::F_READ);

    // ring store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[addr] <= i_cmd.wr_from_mem ? r_mem_q : r_value;
        end
        if (i_cmd.rd_en) begin
            r_mem_q <= r_mem[addr];
        end
    end

    // item capture and shift pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= deq_pkg::t_func'(i_func);
            r_value <= in_word;
            r_index <= i_index;
        end
        if (i_cmd.ptr_init) begin
            r_ptr <= i_cmd.ptr_from_index ? idx_cw : r_count;
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= r_ptr + CW'(1);
        end else if (i_cmd.ptr_dec) begin
            r_ptr <= r_ptr - CW'(1);
        end
        if (i_cmd.commit) begin
            r_out_data   <= rd_result ? mem_word_out : '0;
            r_out_status <= code;
            r_out_count  <= count_out;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_head      <= n_head;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_out_data;
    assign o_status_code = r_out_status;
    assign o_entry_count = r_out_count;

endmodule

[rtl/core/double_ended_queue.sv]
// top level of the double-ended queue
// push, pop, read, write: item loaded, run on the store, then committed as the result
// next item taken once the last commits; insert and erase add a read and a write per moved entry
// the single-port ring store with registered read sets the shift cost
// a result waits in the output register while the next item is taken
// reset (synchronous, active low) empties the queue; no clearing pass over the store
module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [deq_pkg::FUNC_W-1:0]    i_func,
    input  logic [deq_pkg::VALUE_W-1:0]   i_value,
    input  logic [deq_pkg::INDEX_W-1:0]   i_index,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [deq_pkg::RDATA_W-1:0]   o_read_data,
    output logic [deq_pkg::STATUS_W-1:0]  o_status,
    output logic [deq_pkg::COUNT_W-1:0]   o_entry_count
);

    deq_pkg::t_cmd       cmd;
    deq_pkg::t_dp_status dp_status;

    deq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (dp_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    deq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_func        (i_func),
        .i_value       (i_value),
        .i_index       (i_index),
        .i_cmd         (cmd),
        .i_out_stall   (i_out_stall),
        .o_status      (dp_status),
        .o_out_valid   (o_out_valid),
        .o_read_data   (o_read_data),
        .o_status_code (o_status),
        .o_entry_count (o_entry_count)
    );

endmodule

[rtl/core/deq_checker.sv]
// port-level checker for the double-ended queue, bound to the top level
`include "double_ended_queue_assert.svh"

module deq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [deq_pkg::RDATA_W-1:0]   o_read_data,
    input logic [deq_pkg::STATUS_W-1:0]  o_status,
    input logic [deq_pkg::COUNT_W-1:0]   o_entry_count
);

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    `DEQ_ASSERT_NEXT(a_busy_after_accept, in_acc, o_in_stall, "item taken while busy")
    `DEQ_ASSERT_NOW(a_status_code, o_out_valid, o_status <= deq_pkg::ST_FULL, "undefined status code")
    `DEQ_ASSERT_NOW(a_fail_no_data, o_out_valid && (o_status != deq_pkg::ST_OK), o_read_data == '0,
        "failed item carries data")
    `DEQ_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_read_data) && $stable(o_status) && $stable(o_entry_count),
        "stalled result changed")

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_read_data   (o_read_data),
    .o_status      (o_status),
    .o_entry_count (o_entry_count)
);

[verif/double_ended_queue_tb.sv]
// testbench for the double-ended queue: scoreboard class, driving tasks and result checks
module double_ended_queue_tb;

    localparam int QDEPTH = deq_pkg::DEPTH_DEF;

    typedef struct packed {
        logic [deq_pkg::RDATA_W-1:0] rdata;
        deq_pkg::t_status            status;
        logic [deq_pkg::COUNT_W-1:0] held;
    } t_deque_result;

    typedef enum {GROWING, SHRINKING, MIXED} t_fill_mode;

    class t_scoreboard;
        logic [deq_pkg::DATA_WIDTH_DEF-1:0] store [QDEPTH];
        int                                 front;
        int                                 used;
        t_deque_result                      expected_q [$];
        int                                 errors;

        function new();
            front  = 0;
            used   = 0;
            errors = 0;
        endfunction

        function int slot(int pos);
            return (front + pos) % QDEPTH;
        endfunction

        function void note_item(deq_pkg::t_func op, logic [deq_pkg::VALUE_W-1:0] data,
                                logic [deq_pkg::INDEX_W-1:0] pos);
            t_deque_result exp;
            int            i;
            exp.rdata  = '0;
            exp.status = deq_pkg::ST_OK;
            case (op)
                deq_pkg::F_PUSH_BACK: begin
                    if (used >= QDEPTH) begin
                        exp.status = deq_pkg::ST_FULL;
                    end else begin
                        store[slot(used)] = data;
                        used++;
                    end
                end
                deq_pkg::F_PUSH_FRONT: begin
                    if (used >= QDEPTH) begin
                        exp.status = deq_pkg::ST_FULL;
                    end else begin
                        front = (front + QDEPTH - 1) % QDEPTH;
                        store[front] = data;
                        used++;
                    end
                end
                deq_pkg::F_POP_BACK: begin
                    if (used == 0) begin
                        exp.status = deq_pkg::ST_EMPTY;
                    end else begin
                        exp.rdata = store[slot(used - 1)];
                        used--;
                    end
                end
                deq_pkg::F_POP_FRONT: begin
                    if (used == 0) begin
                        exp.status = deq_pkg::ST_EMPTY;
                    end else begin
                        exp.rdata = store[front];
                        front = (front + 1) % QDEPTH;
                        used--;
                    end
                end
                deq_pkg::F_READ: begin
                    if (int'(pos) >= used) exp.status = deq_pkg::ST_EMPTY;
                    else exp.rdata = store[slot(int'(pos))];
                end
                deq_pkg::F_WRITE: begin
                    if (int'(pos) >= used) exp.status = deq_pkg::ST_EMPTY;
                    else store[slot(int'(pos))] = data;
                end
                deq_pkg::F_INSERT: begin
                    if (int'(pos) > used) begin
                        exp.status = deq_pkg::ST_EMPTY;
                    end else if (used >= QDEPTH) begin
                        exp.status = deq_pkg::ST_FULL;
                    end else begin
                        for (i = used; i > int'(pos); i--)
                            store[slot(i)] = store[slot(i - 1)];
                        store[slot(int'(pos))] = data;
                        used++;
                    end
                end
                deq_pkg::F_ERASE: begin
                    if (int'(pos) >= used) begin
                        exp.status = deq_pkg::ST_EMPTY;
                    end else begin
                        for (i = int'(pos); i + 1 < used; i++)
                            store[slot(i)] = store[slot(i + 1)];
                        used--;
                    end
                end
                default: exp.status = deq_pkg::ST_EMPTY;
            endcase
            exp.held = used[deq_pkg::COUNT_W-1:0];
            expected_q = {expected_q, exp};
        endfunction

        function void check_result(logic [deq_pkg::RDATA_W-1:0] rdata,
                                   logic [deq_pkg::STATUS_W-1:0] status,
                                   logic [deq_pkg::COUNT_W-1:0] held);
            t_deque_result exp;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected, read_data %h status %0d count %0d",
                         $time, rdata, status, held);
                errors++;
                return;
            end
            exp = expected_q[0];
            expected_q.delete(0);
            if (rdata !== exp.rdata) begin
                $display("%0t: read_data mismatch, expected %h, got %h", $time, exp.rdata, rdata);
                errors++;
            end
            if (status !== exp.status) begin
                $display("%0t: status mismatch, expected %0d, got %0d", $time, exp.status, status);
                errors++;
            end
            if (held !== exp.held) begin
                $display("%0t: entry_count mismatch, expected %0d, got %0d", $time, exp.held, held);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [deq_pkg::FUNC_W-1:0]    i_func;
    logic [deq_pkg::VALUE_W-1:0]   i_value;
    logic [deq_pkg::INDEX_W-1:0]   i_index;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [deq_pkg::RDATA_W-1:0]   o_read_data;
    logic [deq_pkg::STATUS_W-1:0]  o_status;
    logic [deq_pkg::COUNT_W-1:0]   o_entry_count;

    t_scoreboard sb;
    int          in_idle_pct;
    int          out_stall_pct;
    t_fill_mode  fill_mode;

    double_ended_queue i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_value       (i_value),
        .i_index       (i_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_data   (o_read_data),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_read_data, o_status, o_entry_count);
    end

    task automatic send(deq_pkg::t_func op, logic [deq_pkg::VALUE_W-1:0] data,
                        logic [deq_pkg::INDEX_W-1:0] pos);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= op;
        i_value    <= data;
        i_index    <= pos;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_item(op, data, pos);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
    endtask

    task automatic random_item();
        deq_pkg::t_func               op;
        logic [deq_pkg::VALUE_W-1:0]  data;
        logic [deq_pkg::INDEX_W-1:0]  pos;
        int                           r;
        int                           lim;
        r = $urandom_range(99);
        case (fill_mode)
            GROWING: begin
                if (r < 40)      op = deq_pkg::F_PUSH_BACK;
                else if (r < 75) op = deq_pkg::F_PUSH_FRONT;
                else if (r < 85) op = deq_pkg::F_INSERT;
                else if (r < 90) op = deq_pkg::F_READ;
                else if (r < 94) op = deq_pkg::F_WRITE;
                else if (r < 96) op = deq_pkg::F_POP_BACK;
                else if (r < 98) op = deq_pkg::F_POP_FRONT;
                else             op = deq_pkg::F_ERASE;
            end
            SHRINKING: begin
                if (r < 40)      op = deq_pkg::F_POP_BACK;
                else if (r < 75) op = deq_pkg::F_POP_FRONT;
                else if (r < 83) op = deq_pkg::F_ERASE;
                else if (r < 89) op = deq_pkg::F_READ;
                else if (r < 93) op = deq_pkg::F_WRITE;
                else if (r < 96) op = deq_pkg::F_PUSH_BACK;
                else if (r < 98) op = deq_pkg::F_PUSH_FRONT;
                else             op = deq_pkg::F_INSERT;
            end
            default: begin
                case (r % 8)
                    0:       op = deq_pkg::F_PUSH_BACK;
                    1:       op = deq_pkg::F_PUSH_FRONT;
                    2:       op = deq_pkg::F_POP_BACK;
                    3:       op = deq_pkg::F_POP_FRONT;
                    4:       op = deq_pkg::F_READ;
                    5:       op = deq_pkg::F_WRITE;
                    6:       op = deq_pkg::F_INSERT;
                    default: op = deq_pkg::F_ERASE;
                endcase
            end
        endcase
        case ($urandom_range(9))
            0:       data = '0;
            1:       data = '1;
            default: data = $urandom;
        endcase
        // mostly in range, with the boundary and the odd stray index
        case ($urandom_range(9))
            0:       lim = $urandom_range(255);
            1:       lim = sb.used;
            2:       lim = (sb.used > 0) ? sb.used - 1 : 0;
            default: lim = $urandom_range(sb.used);
        endcase
        pos = (lim > 255) ? 8'd255 : lim[deq_pkg::INDEX_W-1:0];
        send(op, data, pos);
        case (fill_mode)
            GROWING:   if (sb.used == QDEPTH && $urandom_range(9) == 0) fill_mode = SHRINKING;
            SHRINKING: begin
                if (sb.used == 0 && $urandom_range(4) == 0)
                    fill_mode = ($urandom_range(2) == 0) ? MIXED : GROWING;
            end
            default:   if ($urandom_range(99) == 0) fill_mode = GROWING;
        endcase
    endtask

    task automatic random_phase(int idle_in, int stall_out);
        int n;
        in_idle_pct   = idle_in;
        out_stall_pct = stall_out;
        for (n = 0; n < 383; n++) begin
            random_item();
            if (n == 190) wait_drained();
        end
    endtask

    initial begin
        #20000000;
        $display("double_ended_queue verification failed");
        $finish;
    end

    initial begin
        sb            = new();
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_func        = deq_pkg::F_PUSH_BACK;
        i_value       = '0;
        i_index       = '0;
        i_out_stall   = 1'b0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        fill_mode     = GROWING;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // corner cases on an empty queue, then on a partly filled queue at its index bounds, drained back to empty
        send(deq_pkg::F_POP_BACK, 32'h1234_5678, 8'd0);
        send(deq_pkg::F_POP_FRONT, 32'h0, 8'd0);
        send(deq_pkg::F_READ, 32'h0, 8'd0);
        send(deq_pkg::F_WRITE, 32'hDEAD_BEEF, 8'd0);
        send(deq_pkg::F_ERASE, 32'h0, 8'd0);
        send(deq_pkg::F_INSERT, 32'h5555_AAAA, 8'd1);
        send(deq_pkg::F_INSERT, 32'hFFFF_FFFF, 8'd0);
        send(deq_pkg::F_PUSH_BACK, 32'h0000_0000, 8'd255);
        send(deq_pkg::F_PUSH_FRONT, 32'hA5A5_5A5A, 8'd0);
        send(deq_pkg::F_READ, 32'h0, 8'd0);
        send(deq_pkg::F_READ, 32'h0, 8'd1);
        send(deq_pkg::F_READ, 32'h0, 8'd2);
        send(deq_pkg::F_WRITE, 32'h8000_0001, 8'd2);
        send(deq_pkg::F_READ, 32'h0, 8'd3);
        send(deq_pkg::F_INSERT, 32'h7FFF_FFFE, 8'd1);
        send(deq_pkg::F_INSERT, 32'h0F0F_F0F0, 8'd4);
        send(deq_pkg::F_INSERT, 32'h1111_1111, 8'd255);
        send(deq_pkg::F_READ, 32'h0, 8'd255);
        send(deq_pkg::F_ERASE, 32'h0, 8'd0);
        send(deq_pkg::F_ERASE, 32'h0, 8'd1);
        send(deq_pkg::F_ERASE, 32'h0, 8'd2);
        send(deq_pkg::F_ERASE, 32'h0, 8'd2);
        send(deq_pkg::F_POP_BACK, 32'h0, 8'd0);
        send(deq_pkg::F_POP_FRONT, 32'h0, 8'd0);
        send(deq_pkg::F_POP_FRONT, 32'h0, 8'd0);

        random_phase(13, 54);
        random_phase(54, 13);
        random_phase(0, 0);

        wait_drained();
        repeat (12) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("double_ended_queue verification clean");
        end else begin
            $display("double_ended_queue verification failed");
        end
        $finish;
    end
endmodule
